// ===== rtl/life_generation_torus_macros.svh =====
// Assertion helpers for the life board block.
`ifndef LIFE_GENERATION_TORUS_MACROS_SVH
`define LIFE_GENERATION_TORUS_MACROS_SVH

// same-cycle implication, disabled during reset
`define LGT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LGT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lgt_pkg.sv =====
`default_nettype none

package lgt_pkg;

    localparam int ROW_W          = 64;
    localparam int DIM_W          = 7;
    localparam int ROWNUM_W       = 6;
    localparam int FETCH_W        = 8;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [3:0] NB_BIRTH   = 4'd3;
    localparam logic [3:0] NB_SURVIVE = 4'd2;

    typedef enum logic [0:0] {
        REG_BOARD_WIDTH  = 1'b0,
        REG_BOARD_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_SHIFT,
        S_EVAL,
        S_WAIT
    } state_t;

    // B3/S23 on the eight neighbor bits
    function automatic logic life_next(input logic [7:0] nb, input logic alive);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, nb[i]};
        end
        return (n == NB_BIRTH) || (alive && (n == NB_SURVIVE));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/life_generation_torus.sv =====
// After the last row is taken, row 0 and the rows around it are read into the window, then
// the first result row is evaluated and handed off; each later row needs a read, a window
// shift, an evaluate and a hand off, plus any result stall; h+2 row reads per generation.
// Loading takes one row per cycle unless config is pending; no row is taken while emitting.
// Reset (rst_n, async, active low): idle in load mode, width and height 64, no rows loaded.
// The board memory is not cleared; every row is written before it is read.
`default_nettype none

`include "life_generation_torus_macros.svh"

module life_generation_torus
    import lgt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [DIM_W-1:0]    cfg_data,
    input  wire logic                row_valid,
    output logic                     row_stall,
    input  wire logic [ROW_W-1:0]    row_cells,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [ROW_W-1:0]         next_row_cells,
    output logic [ROWNUM_W-1:0]      row_number,
    output logic                     last_row
);

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW = MAX_WIDTH;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   loaded_reg, loaded_next;
    logic [FETCH_W-1:0] fetch_reg, fetch_next;
    logic [DIM_W-1:0]   y_reg, y_next;

    logic [MW-1:0] above_reg, above_next;
    logic [MW-1:0] cur_reg, cur_next;
    logic [MW-1:0] below_reg, below_next;
    logic [MW-1:0] res_reg, res_next;
    logic          last_reg, last_next;
    logic [ROWNUM_W-1:0] rownum_reg, rownum_next;

    logic [MW-1:0] mem [MAX_HEIGHT];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [XW-1:0]    wm1;
    logic [MW-1:0]    wmask;
    logic             row_acc, cfg_acc, res_acc, load_done;
    logic [MW-1:0]    gen_row;

    assign row_acc = row_valid && !row_stall;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign res_acc = result_valid && !result_stall;

    // clamp configured dimensions
    always_comb
    begin
        if (width_reg == '0)
            w_eff = 7'd1;
        else if (width_reg > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = 7'd1;
        else if (height_reg > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign wm1 = XW'(w_eff - 7'd1);

    always_comb
    begin
        for (int x = 0; x < MW; x++)
        begin
            wmask[x] = (x < w_eff);
        end
    end

    assign load_done = (loaded_reg + 7'd1) >= h_eff;

    // read order: h-1, 0, 1, ..., h-1, 0
    always_comb
    begin
        if (fetch_reg == '0)
            rd_addr = AW'(h_eff - 7'd1);
        else if (fetch_reg > FETCH_W'(h_eff))
            rd_addr = '0;
        else
            rd_addr = AW'(fetch_reg - 8'd1);
    end

    // one generation row from the three-row window
    always_comb
    begin
        logic [MW-1:0] al, ar, cl, cr, bl, br;
        al = above_reg << 1;
        ar = above_reg >> 1;
        cl = cur_reg << 1;
        cr = cur_reg >> 1;
        bl = below_reg << 1;
        br = below_reg >> 1;
        // horizontal wrap at the configured width
        al[0]   = above_reg[wm1];
        cl[0]   = cur_reg[wm1];
        bl[0]   = below_reg[wm1];
        ar[wm1] = above_reg[0];
        cr[wm1] = cur_reg[0];
        br[wm1] = below_reg[0];
        for (int x = 0; x < MW; x++)
        begin
            gen_row[x] = wmask[x] && life_next({al[x], above_reg[x], ar[x], cl[x], cr[x],
                                                bl[x], below_reg[x], br[x]}, cur_reg[x]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (row_acc && load_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (fetch_reg >= 8'd3)
                    state_next = S_EVAL;
                else
                    state_next = S_READ;
            end
            S_EVAL:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!result_stall)
                    state_next = last_reg ? S_LOAD : S_READ;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        row_stall    = 1'b1;
        cfg_ready    = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                // a pending config request goes first; rows wait
                row_stall = cfg_valid;
                cfg_ready = 1'b1;
            end
            S_WAIT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                row_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        loaded_next = loaded_reg;
        fetch_next  = fetch_reg;
        y_next      = y_reg;
        above_next  = above_reg;
        cur_next    = cur_reg;
        below_next  = below_reg;
        res_next    = res_reg;
        last_next   = last_reg;
        rownum_next = rownum_reg;

        if (cfg_acc)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOARD_WIDTH:  width_next  = cfg_data;
                REG_BOARD_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
            loaded_next = '0;
        end
        else if (row_acc)
        begin
            if (load_done)
            begin
                loaded_next = '0;
                fetch_next  = '0;
                y_next      = '0;
            end
            else
            begin
                loaded_next = loaded_reg + 7'd1;
            end
        end

        case (state_reg)
            S_READ:
            begin
                fetch_next = fetch_reg + 8'd1;
            end
            S_SHIFT:
            begin
                above_next = cur_reg;
                cur_next   = below_reg;
                below_next = rd_data_reg;
            end
            S_EVAL:
            begin
                res_next    = gen_row;
                rownum_next = ROWNUM_W'(y_reg);
                last_next   = (y_reg == (h_eff - 7'd1));
            end
            S_WAIT:
            begin
                if (res_acc)
                    y_next = y_reg + 7'd1;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            loaded_reg <= '0;
            fetch_reg  <= '0;
            y_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            loaded_reg <= loaded_next;
            fetch_reg  <= fetch_next;
            y_reg      <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg  <= above_next;
        cur_reg    <= cur_next;
        below_reg  <= below_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
        rownum_reg <= rownum_next;
    end

    // board memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (row_acc)
            mem[AW'(loaded_reg)] <= row_cells[MW-1:0] & wmask;
        rd_data_reg <= mem[rd_addr];
    end

    assign next_row_cells = ROW_W'(res_reg);
    assign row_number     = rownum_reg;
    assign last_row       = last_reg;

    `LGT_ASSERT_IMP(a_no_load_while_emit, result_valid, row_stall, "row taken during emit")
    `LGT_ASSERT_IMP(a_last_row_index, result_valid && last_row,
        row_number == ROWNUM_W'(h_eff - 7'd1), "last row flag on wrong row")
    `LGT_ASSERT_NXT(a_back_to_load, res_acc && last_row, state_reg == S_LOAD,
        "not back in load after last row")
    `LGT_ASSERT_IMP(a_loaded_in_range, state_reg == S_LOAD, loaded_reg < h_eff,
        "load count past height")

endmodule

`default_nettype wire

// ===== sim/life_generation_torus_tb.sv =====
`timescale 1ns / 100ps

module life_generation_torus_tb;

    import lgt_pkg::*;

    localparam int RANDOM_ROWS = 370;
    localparam int IDLE_PAD    = 24;
    localparam int DRAIN_PAD   = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_LEN    = 31;

    localparam logic [ROW_W-1:0] ALL_LIVE = '1;

    typedef enum logic [0:0] {
        STEP_CFG,
        STEP_ROW
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        cfg_reg_t           target;
        logic [DIM_W-1:0]   value;
        logic [ROW_W-1:0]   cells;
        logic               pinned;
        logic [ROW_W-1:0]   pinned_cells;
    } step_t;

    typedef struct {
        logic [ROW_W-1:0]    cells;
        logic [ROWNUM_W-1:0] num;
        logic                last;
    } gen_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [DIM_W-1:0]    cfg_data;
    logic                row_valid;
    logic                row_stall;
    logic [ROW_W-1:0]    row_cells;
    logic                result_valid;
    logic                result_stall;
    logic [ROW_W-1:0]    next_row_cells;
    logic [ROWNUM_W-1:0] row_number;
    logic                last_row;

    // predictor state
    logic [ROW_W-1:0] board_rows [DEF_MAX_HEIGHT];
    int               rows_in;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    gen_row_t         pending_rows [$];

    // pinned expectation for a one-row board, set by the driver with its row
    logic             pinned_valid;
    logic [ROW_W-1:0] pinned_cells;

    step_t            plan [PLAN_LEN];
    int               burst_left;
    int               rows_sent;
    int               generations;
    int               results_checked;
    int               reg_writes;
    int               errors;
    int               cycle_count;
    stall_mode_t      stall_mode;
    int               stall_run;

    life_generation_torus u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row_valid      (row_valid),
        .row_stall      (row_stall),
        .row_cells      (row_cells),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .next_row_cells (next_row_cells),
        .row_number     (row_number),
        .last_row       (last_row)
    );

    always #5 clk = ~clk;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int limit);
        if (v == 0)
        begin
            return 1;
        end
        return (v > limit) ? limit : int'(v);
    endfunction

    // one row of the next generation; neighbors wrap, repeated positions count again
    function automatic logic [ROW_W-1:0] next_gen_row(input int y, input int w, input int h);
        logic [ROW_W-1:0] r;
        int n;
        r = '0;
        for (int x = 0; x < w; x++)
        begin
            n = 0;
            for (int dy = 0; dy < 3; dy++)
            begin
                for (int dx = 0; dx < 3; dx++)
                begin
                    if (!(dx == 1 && dy == 1))
                    begin
                        n += board_rows[(y + h + dy - 1) % h][(x + w + dx - 1) % w];
                    end
                end
            end
            if (board_rows[y][x])
            begin
                r[x] = (n == NB_SURVIVE) || (n == NB_BIRTH);
            end
            else
            begin
                r[x] = (n == NB_BIRTH);
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        gen_row_t         want;
        int               w;
        int               h;
        logic [ROW_W-1:0] mask;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BOARD_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else
                begin
                    height_reg = cfg_data;
                end
                rows_in = 0;
            end
            if (row_valid && !row_stall)
            begin
                w = clamp_dim(width_reg, DEF_MAX_WIDTH);
                h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
                mask = (w >= ROW_W) ? ALL_LIVE : ((64'd1 << w) - 64'd1);
                if (rows_in >= h)
                begin
                    rows_in = 0;
                end
                board_rows[rows_in] = row_cells & mask;
                rows_in++;
                if (rows_in == h)
                begin
                    rows_in = 0;
                    generations++;
                    if (pinned_valid)
                    begin
                        want.cells = pinned_cells;
                        want.num   = '0;
                        want.last  = 1'b1;
                        pending_rows.push_back(want);
                    end
                    else
                    begin
                        for (int y = 0; y < h; y++)
                        begin
                            want.cells = next_gen_row(y, w, h);
                            want.num   = y[ROWNUM_W-1:0];
                            want.last  = (y == h - 1);
                            pending_rows.push_back(want);
                        end
                    end
                end
            end
            if (result_valid && !result_stall)
            begin
                if (pending_rows.size() == 0)
                begin
                    errors++;
                    $display("%0t: result row %0d arrived with nothing expected, cells %h",
                             $time, row_number, next_row_cells);
                end
                else
                begin
                    want = pending_rows.pop_front();
                    results_checked++;
                    if (next_row_cells !== want.cells)
                    begin
                        errors++;
                        $display("%0t: next_row_cells expected %h, got %h",
                                 $time, want.cells, next_row_cells);
                    end
                    if (row_number !== want.num)
                    begin
                        errors++;
                        $display("%0t: row_number expected %0d, got %0d",
                                 $time, want.num, row_number);
                    end
                    if (last_row !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_row expected %b, got %b",
                                 $time, want.last, last_row);
                    end
                end
            end
        end
    end

    // result side: stall behavior switches between randomly chosen modes
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(8, 60);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:     result_stall = 1'b0;
            STALL_LIGHT:    result_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall = ($urandom_range(0, 9) < 7);
            default:        result_stall = (cycle_count % 3) != 0;
        endcase
    end

    task automatic write_reg(input cfg_reg_t target, input logic [DIM_W-1:0] value);
        row_valid = 1'b0;
        while (pending_rows.size() != 0)
        begin
            @(negedge clk);
        end
        // partial loads give no results; let the block settle before the write
        repeat (IDLE_PAD) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = target;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    task automatic send_row(input logic [ROW_W-1:0] cells, input logic pin,
                            input logic [ROW_W-1:0] pin_cells);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (gap > 0)
        begin
            row_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        row_valid    = 1'b1;
        row_cells    = cells;
        pinned_valid = pin;
        pinned_cells = pin_cells;
        do @(posedge clk); while (row_stall);
        @(negedge clk);
        rows_sent++;
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : driver
        logic [DIM_W-1:0] corner_dims [6];
        logic [DIM_W-1:0] tall_dims [3];
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        logic [DIM_W-1:0] cur_height;
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        logic [ROW_W-1:0] r3;
        int               big_left;
        int               sel;
        int               h;
        int               n_rows;
        int               random_end;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BOARD_WIDTH;
        cfg_data     = '0;
        row_valid    = 1'b0;
        row_cells    = '0;
        result_stall = 1'b0;
        pinned_valid = 1'b0;
        pinned_cells = '0;
        width_reg    = DIM_RESET;
        height_reg   = DIM_RESET;
        rows_in      = 0;
        burst_left   = 0;
        rows_sent    = 0;
        generations  = 0;
        results_checked = 0;
        reg_writes   = 0;
        errors       = 0;
        stall_run    = 0;
        stall_mode   = STALL_NONE;
        corner_dims  = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
        tall_dims    = '{7'd64, 7'd100, 7'd127};
        cur_height   = DIM_RESET;
        big_left     = 3;

        plan = '{
            // one-cell board: a live cell sees itself eight times and dies
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd1,   64'd0, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_HEIGHT, 7'd1,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'd1, 1'b1, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'd0, 1'b1, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   ALL_LIVE, 1'b1, 64'd0},
            // zero width and height clamp to one
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd0,   64'd0, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_HEIGHT, 7'd0,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   ALL_LIVE, 1'b1, 64'd0},
            // 3x1: full row dies, lone cell counts itself twice and grows to a full row
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd3,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h7, 1'b1, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'hFFFF_FFFF_FFFF_FFF9, 1'b1, 64'h7},
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd64,  64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   ALL_LIVE, 1'b1, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h8000_0000_0000_0001, 1'b0, 64'd0},
            // oversize width clamps to 64
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd127, 64'd0, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_HEIGHT, 7'd2,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'hC000_0000_0000_0003, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h8000_0000_0000_0007, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd2,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h1, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h3, 1'b0, 64'd0},
            // partial load under oversize height, then a height write restarts loading
            '{STEP_CFG, REG_BOARD_WIDTH,  7'd5,   64'd0, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_HEIGHT, 7'd100, 64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_CFG, REG_BOARD_HEIGHT, 7'd4,   64'd0, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h4, 1'b0, 64'd0},
            '{STEP_ROW, REG_BOARD_WIDTH,  7'd0,   64'h0, 1'b0, 64'd0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                write_reg(plan[i].target, plan[i].value);
                if (plan[i].target == REG_BOARD_HEIGHT)
                begin
                    cur_height = plan[i].value;
                end
            end
            else
            begin
                send_row(plan[i].cells, plan[i].pinned, plan[i].pinned_cells);
            end
        end

        random_end = rows_sent + RANDOM_ROWS;
        while (rows_sent < random_end)
        begin
            w_val = ($urandom_range(0, 7) == 0) ? corner_dims[$urandom_range(0, 5)]
                                                 : 7'($urandom_range(1, 64));
            if (big_left > 0 && $urandom_range(0, 11) == 0)
            begin
                big_left--;
                h_val = tall_dims[$urandom_range(0, 2)];
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                h_val = 7'($urandom_range(0, 2));
            end
            else
            begin
                h_val = 7'($urandom_range(1, 8));
            end
            // 0: width only, 1: height only, 2-3: both, 4: keep settings and reload
            sel = $urandom_range(0, 4);
            if (sel == 0 || sel == 3)
            begin
                write_reg(REG_BOARD_WIDTH, w_val);
            end
            if (sel == 1 || sel == 2 || sel == 3)
            begin
                write_reg(REG_BOARD_HEIGHT, h_val);
                cur_height = h_val;
            end
            if (sel == 2)
            begin
                write_reg(REG_BOARD_WIDTH, w_val);
            end
            h = clamp_dim(cur_height, DEF_MAX_HEIGHT);
            n_rows = (h > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, h - 1) : h;
            for (int k = 0; k < n_rows; k++)
            begin
                r1 = {$urandom, $urandom};
                r2 = {$urandom, $urandom};
                r3 = {$urandom, $urandom};
                case ($urandom_range(0, 3))
                    0:       send_row(r1, 1'b0, '0);
                    1:       send_row(r1 & r2, 1'b0, '0);
                    2:       send_row(r1 | r2, 1'b0, '0);
                    default: send_row(r1 & r2 & r3, 1'b0, '0);
                endcase
            end
        end
        row_valid = 1'b0;

        while (pending_rows.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_PAD) @(negedge clk);

        $display("Loaded %0d board rows into %0d generations; checked %0d result rows after %0d register writes.",
                 rows_sent, generations, results_checked, reg_writes);
        $display("Boards ranged from 1x1 to 64x64, with clamped zero and oversize settings and restarts mid-load.");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lgt_pkg.sv
rtl/life_generation_torus.sv
sim/life_generation_torus_tb.sv
